// ===== sv/swmm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmm_pkg
// Shared types and constants of the sliding window min/max block.
// ----------------------------------------------------------------------------
package swmm_pkg;

  localparam int POS_BITS      = 16;
  localparam int CFG_DATA_BITS = 7;
  localparam int CFG_IDX_BITS  = 1;

  localparam logic [CFG_IDX_BITS-1:0]  CFG_WINDOW_LEN = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0]  CFG_FIND_MAX   = 1'b1;
  localparam logic [CFG_DATA_BITS-1:0] WLEN_RESET     = 7'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RET_RD,
    ST_RET_CHK,
    ST_POP_RD,
    ST_POP_CHK,
    ST_APPEND,
    ST_RES_RD,
    ST_RES_OUT
  } swmm_state_e;

  typedef struct packed {
    logic in_ready;
    logic load_in;
    logic mem_rd;
    logic rd_tail;
    logic retire;
    logic pop;
    logic append;
    logic load_out;
  } swmm_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic retire_hit;
    logic drop_hit;
    logic result_due;
    logic out_busy;
  } swmm_status_t;

endpackage

// ===== sv/swmm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmm_sample_if / swmm_result_if
// Valid/ready channels for samples in and window extremes out.
// ----------------------------------------------------------------------------
interface swmm_sample_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface swmm_result_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] extreme_value;
  logic [15:0]                   extreme_position;

  modport source (output valid, output extreme_value, output extreme_position, input ready);
  modport sink   (input valid, input extreme_value, input extreme_position, output ready);
endinterface

// ===== sv/swmm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmm_ctrl
// Sequencer: retire old entries, drop dominated ones, append, report.
// ----------------------------------------------------------------------------
module swmm_ctrl
  import swmm_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  swmm_status_t status_i,
  output swmm_cmd_t    cmd_o
);

  swmm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_RET_RD;
        end
      end
      ST_RET_RD: begin
        if (status_i.count_zero) begin
          state_d = ST_POP_RD;
        end else begin
          cmd_o.mem_rd = 1'b1;
          state_d      = ST_RET_CHK;
        end
      end
      ST_RET_CHK: begin
        if (status_i.retire_hit) begin
          cmd_o.retire = 1'b1;
          state_d      = ST_RET_RD;
        end else begin
          state_d = ST_POP_RD;
        end
      end
      ST_POP_RD: begin
        if (status_i.count_zero) begin
          state_d = ST_APPEND;
        end else begin
          cmd_o.mem_rd  = 1'b1;
          cmd_o.rd_tail = 1'b1;
          state_d       = ST_POP_CHK;
        end
      end
      ST_POP_CHK: begin
        if (status_i.drop_hit) begin
          cmd_o.pop = 1'b1;
          state_d   = ST_POP_RD;
        end else begin
          state_d = ST_APPEND;
        end
      end
      ST_APPEND: begin
        cmd_o.append = 1'b1;
        state_d      = status_i.result_due ? ST_RES_RD : ST_IDLE;
      end
      ST_RES_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = ST_RES_OUT;
      end
      ST_RES_OUT: begin
        // hold until the output register can take the result
        if (!status_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/swmm_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmm_datapath
// Deque storage, pointers, counters, configuration and output register.
// ----------------------------------------------------------------------------
module swmm_datapath
  import swmm_pkg::*;
#(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0]      cfg_wdata_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          restart_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic signed [SAMPLE_BITS-1:0] out_value_o,
  output logic [POS_BITS-1:0]           out_pos_o,
  input  swmm_cmd_t                     cmd_i,
  output swmm_status_t                  status_o
);

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int EW = SAMPLE_BITS + POS_BITS;

  function automatic logic [AW-1:0] wrap_idx(input logic [AW:0] s);
    if (s >= (AW+1)'(WINDOW_MAX)) begin
      return AW'(s - (AW+1)'(WINDOW_MAX));
    end
    return AW'(s);
  endfunction

  logic [CFG_DATA_BITS-1:0]      wlen_q;
  logic                          fmax_q;
  logic [AW-1:0]                 head_q;
  logic [CW-1:0]                 count_q;
  logic [POS_BITS-1:0]           pos_q;
  logic [CW-1:0]                 warm_q;
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic [EW-1:0]                 rdata_q;
  logic signed [SAMPLE_BITS-1:0] out_value_q;
  logic [POS_BITS-1:0]           out_pos_q;
  logic [EW-1:0]                 mem_q [WINDOW_MAX];

  logic [CW-1:0]                 win_len;
  logic [CW-1:0]                 warm_next;
  logic [AW-1:0]                 head_inc;
  logic [AW-1:0]                 tail_idx;
  logic [AW-1:0]                 wr_idx;
  logic [AW-1:0]                 rd_idx;
  logic                          count_full;
  logic signed [SAMPLE_BITS-1:0] rd_value;
  logic [POS_BITS-1:0]           rd_pos;
  logic [POS_BITS-1:0]           age;

  // clamp the window length into 1..WINDOW_MAX
  always_comb begin
    if (wlen_q == '0) begin
      win_len = CW'(1);
    end else if (int'(wlen_q) > WINDOW_MAX) begin
      win_len = CW'(WINDOW_MAX);
    end else begin
      win_len = CW'(wlen_q);
    end
  end

  assign rd_value   = rdata_q[EW-1:POS_BITS];
  assign rd_pos     = rdata_q[POS_BITS-1:0];
  assign age        = pos_q - rd_pos;
  assign count_full = (count_q == CW'(WINDOW_MAX));
  assign head_inc   = (head_q == AW'(WINDOW_MAX - 1)) ? '0 : head_q + AW'(1);
  assign tail_idx   = wrap_idx((AW+1)'(head_q) + (AW+1)'(count_q) - (AW+1)'(1));
  assign wr_idx     = count_full ? head_q : wrap_idx((AW+1)'(head_q) + (AW+1)'(count_q));
  assign rd_idx     = cmd_i.rd_tail ? tail_idx : head_q;
  assign warm_next  = (warm_q < win_len) ? warm_q + CW'(1) : win_len;

  assign status_o.count_zero = (count_q == '0);
  assign status_o.retire_hit = (age >= POS_BITS'(win_len));
  assign status_o.drop_hit   = fmax_q ? (sample_q > rd_value) : (sample_q < rd_value);
  assign status_o.result_due = (warm_next == win_len);
  assign status_o.out_busy   = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q      <= WLEN_RESET;
      fmax_q      <= 1'b0;
      head_q      <= '0;
      count_q     <= '0;
      pos_q       <= '0;
      warm_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_WINDOW_LEN: wlen_q <= cfg_wdata_i;
          CFG_FIND_MAX:   fmax_q <= cfg_wdata_i[0];
          default:        ;
        endcase
      end
      if (cmd_i.load_in && restart_i) begin
        head_q  <= '0;
        count_q <= '0;
        pos_q   <= '0;
        warm_q  <= '0;
      end
      if (cmd_i.retire) begin
        head_q  <= head_inc;
        count_q <= count_q - CW'(1);
      end
      if (cmd_i.pop) begin
        count_q <= count_q - CW'(1);
      end
      if (cmd_i.append) begin
        // a full deque overwrites its oldest slot
        if (count_full) begin
          head_q <= head_inc;
        end else begin
          count_q <= count_q + CW'(1);
        end
        pos_q  <= pos_q + POS_BITS'(1);
        warm_q <= warm_next;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      sample_q <= sample_i;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem_q[rd_idx];
    end
    if (cmd_i.load_out) begin
      out_value_q <= rd_value;
      out_pos_q   <= rd_pos;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      mem_q[wr_idx] <= {sample_q, pos_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_pos_o   = out_pos_q;

endmodule

// ===== sv/sliding_window_min_max.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_min_max
// Streaming minimum or maximum over the last window_len samples.
// ----------------------------------------------------------------------------
// Each sample enters a monotonic deque of (value, position) pairs held in a
// single-port-read memory of WINDOW_MAX entries. A sample first retires the
// entries that fall out of the window from the oldest end, then drops the
// entries it dominates from the newest end (larger ones in minimum mode,
// smaller ones in maximum mode), then is appended. Once window_len samples
// have been seen since reset or restart, the oldest entry is reported as the
// window extreme with its stream position (mod 65536); ties keep the oldest
// position. Every examined entry, retired, dropped or a survivor read at
// either end of the deque, costs one memory read and one compare through the
// one read port, and a result costs one more read of the oldest entry. A
// finished result waits in an output register, so the next sample is taken
// while it waits; a new result stalls only while that register is still full.
// Configuration: index CFG_WINDOW_LEN sets window_len (0 acts as 1, larger
// than WINDOW_MAX acts as WINDOW_MAX), index CFG_FIND_MAX picks the mode.
// Write configuration only while the block is idle. The deque needs no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module sliding_window_min_max
  import swmm_pkg::*;
#(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  swmm_sample_if.sink              sample_i,
  swmm_result_if.source            result_o
);

  swmm_cmd_t    cmd;
  swmm_status_t status;

  // sequencer: one memory access per examined entry
  swmm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // deque memory, pointers, counters and result register
  swmm_datapath #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (sample_i.sample),
    .restart_i   (sample_i.restart),
    .out_ready_i (result_o.ready),
    .out_valid_o (result_o.valid),
    .out_value_o (result_o.extreme_value),
    .out_pos_o   (result_o.extreme_position),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  // take a sample transaction only between items
  assign sample_i.ready = cmd.in_ready;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sliding window min/max block.
// ----------------------------------------------------------------------------
// A short table of directed samples and register writes runs first. It covers
// reset warm-up, the sample extremes, ties, restart, switching between minimum
// and maximum mid-stream, shrinking the window mid-stream, and window lengths
// outside the legal range. A few rows carry hand-written results; the other
// rows, and the random phases that follow, are checked against a behavioral
// deque model kept in this file. Each random phase picks a window length and
// a mode, then streams ramps, clusters of near-equal values, noise and
// extremes with a rare restart. Both channels idle at random, except in one
// phase that runs at full rate.
// ----------------------------------------------------------------------------
module testbench;
  import swmm_pkg::*;

  localparam int WIN_DEPTH    = 64;
  localparam int IDLE_PCT     = 28;
  // A sample can examine every entry once (retire or drop) with a read and
  // a compare each, plus overhead; wait that long before touching registers.
  localparam int SETTLE_CYCLES = 300;
  localparam int RANDOM_ITEMS  = 800;

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_CONFIG} row_kind_e;
  typedef enum logic [1:0] {CHK_MODEL, CHK_RESULT, CHK_NONE} row_check_e;

  typedef struct packed {
    logic signed [15:0] value;
    logic [15:0]        position;
  } extreme_t;

  typedef struct packed {
    row_kind_e                kind;
    logic [CFG_IDX_BITS-1:0]  idx;
    logic signed [15:0]       data;
    logic                     restart;
    row_check_e               chk;
    logic signed [15:0]       exp_value;
    logic [15:0]              exp_position;
  } stim_row_t;

  // Directed table. Config rows use data as the register value.
  stim_row_t directed_rows [0:22] = '{
    // warm-up at reset settings: window of 3, minimum
    '{ROW_SAMPLE, CFG_WINDOW_LEN, 16'sd5,      1'b0, CHK_NONE,   16'sd0,      16'd0},
    '{ROW_SAMPLE, CFG_WINDOW_LEN, 16'sd7,      1'b0, CHK_NONE,   16'sd0,      16'd0},
    '{ROW_SAMPLE, CFG_WINDOW_LEN, 16'sd2,      1'b0, CHK_RESULT, 16'sd2,      16'd2},
    // field extremes and ties: the oldest equal value stays the extreme
    '{ROW_SAMPLE, CFG_WINDOW_LEN, 16'sh8000,   1'b0, CHK_RESULT, 16'sh8000,   16'd3},
    '{ROW_SAMPLE, CFG_WINDOW_LEN, 16'sh7fff,   1'b0, CHK_RESULT, 16'sh8000,   16'd3},
    '{ROW_SAMPLE, CFG_WINDOW_LEN, 16'sh7fff,   1'b0, CHK_RESULT, 16'sh8000,   16'd3},
    '{ROW_SAMPLE, CFG_WINDOW_LEN, 16'sh7fff,   1'b0, CHK_RESULT, 16'sh7fff,   16'd4},
    // restart: positions start over at zero, warm-up again
    '{ROW_SAMPLE, CFG_WINDOW_LEN, 16'sd100,    1'b1, CHK_NONE,   16'sd0,      16'd0},
    '{ROW_SAMPLE, CFG_WINDOW_LEN, 16'sd100,    1'b0, CHK_NONE,   16'sd0,      16'd0},
    '{ROW_SAMPLE, CFG_WINDOW_LEN, 16'sd100,    1'b0, CHK_RESULT, 16'sd100,    16'd0},
    // flip to maximum with a minimum-ordered deque in place
    '{ROW_CONFIG, CFG_FIND_MAX,   16'sd1,      1'b0, CHK_NONE,   16'sd0,      16'd0},
    '{ROW_SAMPLE, CFG_WINDOW_LEN, -16'sd5,     1'b0, CHK_MODEL,  16'sd0,      16'd0},
    '{ROW_SAMPLE, CFG_WINDOW_LEN, 16'sh7fff,   1'b0, CHK_MODEL,  16'sd0,      16'd0},
    // length 0 acts as 1: everything older retires at once
    '{ROW_CONFIG, CFG_WINDOW_LEN, 16'sd0,      1'b0, CHK_NONE,   16'sd0,      16'd0},
    '{ROW_SAMPLE, CFG_WINDOW_LEN, 16'sh8000,   1'b0, CHK_RESULT, 16'sh8000,   16'd5},
    '{ROW_SAMPLE, CFG_WINDOW_LEN, 16'sh7fff,   1'b1, CHK_RESULT, 16'sh7fff,   16'd0},
    // length above the deque depth acts as the depth
    '{ROW_CONFIG, CFG_WINDOW_LEN, 16'sd127,    1'b0, CHK_NONE,   16'sd0,      16'd0},
    '{ROW_SAMPLE, CFG_WINDOW_LEN, 16'sd1,      1'b0, CHK_MODEL,  16'sd0,      16'd0},
    '{ROW_SAMPLE, CFG_WINDOW_LEN, -16'sd1,     1'b0, CHK_MODEL,  16'sd0,      16'd0},
    '{ROW_CONFIG, CFG_WINDOW_LEN, 16'sd64,     1'b0, CHK_NONE,   16'sd0,      16'd0},
    '{ROW_CONFIG, CFG_FIND_MAX,   16'sd0,      1'b0, CHK_NONE,   16'sd0,      16'd0},
    '{ROW_SAMPLE, CFG_WINDOW_LEN, -16'sd2,     1'b0, CHK_MODEL,  16'sd0,      16'd0},
    '{ROW_SAMPLE, CFG_WINDOW_LEN, 16'sd3,      1'b1, CHK_MODEL,  16'sd0,      16'd0}
  };

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i;
  logic [CFG_DATA_BITS-1:0] cfg_wdata_i;

  swmm_sample_if #(.SAMPLE_BITS(16)) smp_if ();
  swmm_result_if #(.SAMPLE_BITS(16)) res_if ();

  sliding_window_min_max #(
    .WINDOW_MAX  (WIN_DEPTH),
    .SAMPLE_BITS (16)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (smp_if),
    .result_o    (res_if)
  );

  // Window model: a circular deque of (value, position) pairs plus counters.
  logic signed [15:0] win_value [WIN_DEPTH];
  logic [15:0]        win_position [WIN_DEPTH];
  logic [5:0]         win_head;
  int unsigned        win_count;
  logic [15:0]        next_position;
  int unsigned        samples_seen;
  logic [6:0]         window_len_reg;
  logic               find_max_reg;

  extreme_t pending_extremes[$];
  int       mismatch_count;
  bit       full_rate;

  initial begin
    clk_i = 1'b0;
  end
  always #4 clk_i = ~clk_i;

  // Result side backpressure: stall at random unless the full-rate phase runs.
  always @(negedge clk_i) begin
    res_if.ready <= full_rate || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Advance the window model by one sample; return 1 when a result is due.
  function automatic bit track_window(input logic signed [15:0] smp, input logic rst_seq,
                                      output extreme_t ext);
    int unsigned span;
    logic [15:0] cur_pos;
    logic [15:0] age;
    logic [5:0]  slot;
    span = (window_len_reg == 0) ? 1 :
           (window_len_reg > WIN_DEPTH) ? WIN_DEPTH : window_len_reg;
    ext = '0;
    if (rst_seq) begin
      win_head      = '0;
      win_count     = 0;
      next_position = '0;
      samples_seen  = 0;
    end
    cur_pos = next_position;
    // retire from the oldest end whatever falls outside the window
    while (win_count > 0) begin
      age = cur_pos - win_position[win_head];
      if (age < span) break;
      win_head  = win_head + 6'd1;
      win_count = win_count - 1;
    end
    // drop dominated entries from the newest end; equal values stay
    while (win_count > 0) begin
      slot = win_head + 6'(win_count - 1);
      if (find_max_reg ? (smp > win_value[slot]) : (smp < win_value[slot]))
        win_count = win_count - 1;
      else
        break;
    end
    slot               = win_head + 6'(win_count);
    win_value[slot]    = smp;
    win_position[slot] = cur_pos;
    win_count          = win_count + 1;
    next_position      = cur_pos + 16'd1;
    if (samples_seen < span) samples_seen++;
    if (samples_seen > span) samples_seen = span;
    if (samples_seen < span) return 1'b0;
    ext.value    = win_value[win_head];
    ext.position = win_position[win_head];
    return 1'b1;
  endfunction

  // Present one sample, hold it until the transaction completes, then log
  // the expected window extreme (from the model or from the table).
  task automatic push_sample(input logic signed [15:0] smp, input logic rst_seq,
                             input row_check_e chk, input extreme_t fixed);
    extreme_t ext;
    bit       due;
    @(negedge clk_i);
    while (!full_rate && ($urandom_range(99) < IDLE_PCT)) begin
      smp_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    smp_if.valid   <= 1'b1;
    smp_if.sample  <= smp;
    smp_if.restart <= rst_seq;
    @(posedge clk_i);
    while (!smp_if.ready) @(posedge clk_i);
    due = track_window(smp, rst_seq, ext);
    case (chk)
      CHK_MODEL:  if (due) pending_extremes.push_back(ext);
      CHK_RESULT: pending_extremes.push_back(fixed);
      default: ;
    endcase
  endtask

  // Write one register with the block idle: drain results, then settle.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk_i);
    smp_if.valid <= 1'b0;
    while (pending_extremes.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_WINDOW_LEN) window_len_reg = val;
    else find_max_reg = val[0];
  endtask

  // Check every result transaction against the oldest expectation.
  always @(posedge clk_i) begin
    extreme_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_extremes.size() == 0) begin
        flag_mismatch($sformatf("unexpected result value=%0d position=%0d",
                                res_if.extreme_value, res_if.extreme_position));
      end else begin
        want = pending_extremes.pop_front();
        if (res_if.extreme_value !== want.value)
          flag_mismatch($sformatf("extreme_value got %0d want %0d",
                                  res_if.extreme_value, want.value));
        if (res_if.extreme_position !== want.position)
          flag_mismatch($sformatf("extreme_position got %0d want %0d",
                                  res_if.extreme_position, want.position));
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    stim_row_t          row;
    int                 sent;
    int                 phase;
    int                 style;
    int                 pick;
    int                 run_len;
    int                 ramp;
    int                 v;
    bit                 rising;
    logic [6:0]         wlen;
    logic signed [15:0] smp;
    logic               rst_seq;

    // Drive every input known before reset releases.
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_WINDOW_LEN;
    cfg_wdata_i    = '0;
    smp_if.valid   = 1'b0;
    smp_if.sample  = '0;
    smp_if.restart = 1'b0;
    res_if.ready   = 1'b0;
    full_rate      = 1'b0;
    mismatch_count = 0;
    win_head       = '0;
    win_count      = 0;
    next_position  = '0;
    samples_seen   = 0;
    window_len_reg = WLEN_RESET;
    find_max_reg   = 1'b0;
    ramp           = 0;
    rising         = 1'b1;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table.
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CONFIG)
        write_reg(row.idx, row.data[CFG_DATA_BITS-1:0]);
      else
        push_sample(row.data, row.restart, row.chk, {row.exp_value, row.exp_position});
    end

    // Random phases: new settings each phase, shaped sample streams.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(9))
        0:       wlen = 7'd0;
        1:       wlen = 7'd1;
        2:       wlen = 7'd64;
        3:       wlen = 7'($urandom_range(65, 127));
        4:       wlen = 7'($urandom_range(13, 63));
        default: wlen = 7'($urandom_range(2, 12));
      endcase
      write_reg(CFG_WINDOW_LEN, wlen);
      write_reg(CFG_FIND_MAX, CFG_DATA_BITS'($urandom_range(1)));
      // one phase runs with neither side idling
      full_rate = (phase == 2);
      style     = $urandom_range(3);
      run_len   = $urandom_range(40, 110);
      repeat (run_len) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          smp = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        end else if (pick < 22 || style == 0) begin
          smp = 16'($urandom);
        end else if (style == 1) begin
          // tight cluster: lots of ties
          v   = $urandom_range(6);
          smp = 16'(v - 3);
        end else begin
          // ramps with random turns keep long deques alive or flush them
          if ($urandom_range(15) == 0) rising = !rising;
          v    = $urandom_range(style == 2 ? 300 : 4000);
          ramp = rising ? ramp + v : ramp - v;
          smp  = 16'(ramp);
        end
        rst_seq = ($urandom_range(49) == 0);
        push_sample(smp, rst_seq, CHK_MODEL, '0);
        sent++;
      end
      full_rate = 1'b0;
      phase++;
    end

    // Drain: release valid, wait for every expected result, then settle.
    @(negedge clk_i);
    smp_if.valid <= 1'b0;
    while (pending_extremes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
